### rtl/itoa_pkg.sv
// itoa_pkg: shared constants, types and the digit-to-ASCII mapping for the
// integer-to-text converter.
// No dependencies; compiled first.
package itoa_pkg;

    localparam int RADIX_W  = 6;
    localparam int CHAR_W   = 7;
    localparam int DIGIT_W  = 6;

    localparam logic [RADIX_W-1:0] MIN_RADIX  = 6'd2;
    localparam logic [RADIX_W-1:0] MAX_RADIX  = 6'd35;
    localparam logic [CHAR_W-1:0]  MINUS_CODE = 7'd45;
    localparam logic [CHAR_W-1:0]  ZERO_CODE  = 7'd48;
    localparam logic [CHAR_W-1:0]  LOWER_A    = 7'd97;
    localparam logic [CHAR_W-1:0]  NO_CHAR    = 7'd0;

    // queue flags seen by the front and back halves
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // digit value to ASCII: '0'-'9', then lower-case letters
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        c = NO_CHAR;
        if (d < 6'd10)
        begin
            c = ZERO_CODE + {1'b0, d};
        end
        else if (d < 6'd36)
        begin
            c = LOWER_A + {1'b0, d} - 7'd10;
        end
        return c;
    endfunction

endpackage

### rtl/itoa_if.sv
// itoa_in_if / itoa_out_if: valid/ready channels for number beats and
// character beats.
// Depends on itoa_pkg for field widths.
interface itoa_in_if
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] number;
    logic [RADIX_W-1:0]     radix;

    modport source (output valid, output number, output radix, input ready);
    modport sink   (input valid, input number, input radix, output ready);
endinterface

interface itoa_out_if
    import itoa_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              final_res;
    logic              bad_base;

    modport source (output valid, output char_code, output final_res, output bad_base,
                    input ready);
    modport sink   (input valid, input char_code, input final_res, input bad_base,
                    output ready);
endinterface

### rtl/itoa_front.sv
// itoa_front: takes number beats, checks the base, splits off the sign and
// forms the unsigned magnitude, then pushes the command into the queue.
// Depends on itoa_pkg and itoa_if.
module itoa_front
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int CMD_W       = VALUE_WIDTH + RADIX_W + 2
)
(
    itoa_in_if.sink           src,
    input  fifo_stat_t        stat,
    output logic              push,
    output logic [CMD_W-1:0]  cmd
);
    logic                   bad;
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;

    // classify: base range, sign, magnitude (most negative value wraps to 2^(W-1))
    always_comb
    begin
        bad = !(src.radix inside {[MIN_RADIX:MAX_RADIX]});
        neg = src.number[VALUE_WIDTH-1];
        mag = neg ? (~src.number + VALUE_WIDTH'(1)) : src.number;
    end

    assign src.ready = !stat.full;
    assign push      = src.valid && !stat.full;
    assign cmd       = {bad, neg, src.radix, mag};

endmodule

### rtl/itoa_fifo.sv
// itoa_fifo: two-entry queue between the front and back halves.
// Depends on itoa_pkg for the status struct.
module itoa_fifo
    import itoa_pkg::*;
#(
    parameter int DATA_W = 40
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] head,
    output fifo_stat_t        stat
);
    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    // entries hold payload only
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);

endmodule

### rtl/itoa_back.sv
// itoa_back: bit-serial restoring divider that peels digits into a small
// store, then emits sign and digits most significant first.
// Depends on itoa_pkg and itoa_if.
module itoa_back
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int CMD_W       = VALUE_WIDTH + RADIX_W + 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CMD_W-1:0] head,
    input  fifo_stat_t       stat,
    output logic             pop,
    itoa_out_if.source       dst
);
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int IDX_W = $clog2(VALUE_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_SIGN,
        S_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] quot_reg, quot_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [RADIX_W-1:0]     base_reg, base_next;
    logic [IDX_W-1:0]       bit_reg, bit_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      out_char_reg, out_char_next;
    logic                   out_final_reg, out_final_next;
    logic                   out_bad_reg, out_bad_next;

    logic [DIGIT_W-1:0]     digit_mem [VALUE_WIDTH];
    logic [DIGIT_W-1:0]     rd_data_reg;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [IDX_W-1:0]       mem_raddr;
    logic [CNT_W-1:0]       cnt_m1;

    // command fields
    logic                   cmd_bad;
    logic                   cmd_neg;
    logic [RADIX_W-1:0]     cmd_radix;
    logic [VALUE_WIDTH-1:0] cmd_mag;

    // divider step
    logic [DIGIT_W:0]       rem_sh;
    logic                   take;
    logic [DIGIT_W:0]       rem_sub;
    logic [VALUE_WIDTH-1:0] quot_sh;
    logic                   out_free;

    assign {cmd_bad, cmd_neg, cmd_radix, cmd_mag} = head;

    assign cnt_m1    = cnt_reg - CNT_W'(1);
    assign mem_raddr = cnt_m1[IDX_W-1:0];
    assign mem_waddr = cnt_reg[IDX_W-1:0];

    // one quotient bit per cycle
    always_comb
    begin
        rem_sh  = {rem_reg, quot_reg[VALUE_WIDTH-1]};
        take    = (rem_sh >= {1'b0, base_reg});
        rem_sub = take ? (rem_sh - {1'b0, base_reg}) : rem_sh;
        quot_sh = {quot_reg[VALUE_WIDTH-2:0], take};
    end

    assign out_free = !out_valid_reg || dst.ready;

    // next-state logic
    always_comb
    begin
        state_next     = state_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        base_next      = base_reg;
        bit_next       = bit_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_final_next = out_final_reg;
        out_bad_next   = out_bad_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;

        if (out_valid_reg && dst.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (!stat.empty)
                begin
                    if (cmd_bad)
                    begin
                        // bad base: one flagged beat, state untouched
                        if (out_free)
                        begin
                            pop            = 1'b1;
                            out_valid_next = 1'b1;
                            out_char_next  = NO_CHAR;
                            out_final_next = 1'b1;
                            out_bad_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        pop        = 1'b1;
                        quot_next  = cmd_mag;
                        rem_next   = '0;
                        base_next  = cmd_radix;
                        bit_next   = '0;
                        cnt_next   = '0;
                        neg_next   = cmd_neg;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                quot_next = quot_sh;
                rem_next  = rem_sub[DIGIT_W-1:0];
                bit_next  = bit_reg + IDX_W'(1);
                if (bit_reg == IDX_W'(VALUE_WIDTH - 1))
                begin
                    // digit done: store remainder, go again on the quotient
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                    rem_next = '0;
                    bit_next = '0;
                    if (quot_sh == '0)
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = neg_reg ? S_SIGN : S_EMIT;
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = MINUS_CODE;
                    out_final_next = 1'b0;
                    out_bad_next   = 1'b0;
                    neg_next       = 1'b0;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = digit_char(rd_data_reg);
                    out_final_next = (cnt_reg == CNT_W'(1));
                    out_bad_next   = 1'b0;
                    cnt_next       = cnt_m1;
                    state_next     = (cnt_reg == CNT_W'(1)) ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            quot_reg      <= '0;
            rem_reg       <= '0;
            base_reg      <= '0;
            bit_reg       <= '0;
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_final_reg <= 1'b0;
            out_bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            quot_reg      <= quot_next;
            rem_reg       <= rem_next;
            base_reg      <= base_next;
            bit_reg       <= bit_next;
            cnt_reg       <= cnt_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_final_reg <= out_final_next;
            out_bad_reg   <= out_bad_next;
        end
    end

    // digit store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_mem[mem_waddr] <= rem_sub[DIGIT_W-1:0];
        end
        rd_data_reg <= digit_mem[mem_raddr];
    end

    assign dst.valid     = out_valid_reg;
    assign dst.char_code = out_char_reg;
    assign dst.final_res = out_final_reg;
    assign dst.bad_base  = out_bad_reg;

endmodule

### rtl/int_to_radix_string_top.sv
// int_to_radix_string_top: signed integer to ASCII text in base 2 to 35.
// Depends on itoa_pkg, itoa_if, itoa_front, itoa_fifo, itoa_back.
//
//   channel   dir  payload                             beat
//   num_ch    in   number[VALUE_WIDTH], radix[6]       one conversion request
//   char_ch   out  char_code[7], final_res, bad_base   one character
//
// Each digit takes one pass of the bit-serial divider over all VALUE_WIDTH bits;
// emission puts out a sign beat first for a negative value, then reads each digit
// from the store and outputs it. A bad base gives a single flagged beat from the
// output register once it reaches the back half, without entering the divider.
// Reset is asynchronous and clears all control state; the digit store is not
// cleared. Both sides stall independently through the two-entry queue and the
// output register.
module int_to_radix_string_top
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    itoa_in_if.sink    num_ch,
    itoa_out_if.source char_ch
);
    localparam int CMD_W = VALUE_WIDTH + RADIX_W + 2;

    logic             push;
    logic             pop;
    logic [CMD_W-1:0] cmd;
    logic [CMD_W-1:0] head;
    fifo_stat_t       stat;

    itoa_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .CMD_W       (CMD_W)
    ) u_front (
        .src  (num_ch),
        .stat (stat),
        .push (push),
        .cmd  (cmd)
    );

    itoa_fifo #(
        .DATA_W (CMD_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cmd),
        .pop       (pop),
        .head      (head),
        .stat      (stat)
    );

    itoa_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .CMD_W       (CMD_W)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .stat  (stat),
        .pop   (pop),
        .dst   (char_ch)
    );

`ifndef SYNTHESIS
    // queue never overflows or underflows
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !stat.full || pop)
        else $error("queue push while full");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !stat.empty)
        else $error("queue pop while empty");
    // bad-base beat is a lone, final NUL
    assert property (@(posedge clk) disable iff (!rst_n)
        char_ch.valid && char_ch.bad_base |-> char_ch.final_res && char_ch.char_code == NO_CHAR)
        else $error("bad-base beat malformed");
    // a normal beat always carries a printable code
    assert property (@(posedge clk) disable iff (!rst_n)
        char_ch.valid && !char_ch.bad_base |-> char_ch.char_code != NO_CHAR)
        else $error("empty character on a good beat");
`endif

endmodule

### test/tb_int_to_radix_string_top.sv
// tb_int_to_radix_string_top: self-checking bench for the integer-to-text converter.
// Depends on itoa_pkg, itoa_if and int_to_radix_string_top from rtl/; drives number
// beats, checks every character beat against a local predictor or a typed-in string.
module tb_int_to_radix_string_top;
    import itoa_pkg::*;

    localparam int VALUE_WIDTH  = 32;
    localparam int MAX_DIGITS   = VALUE_WIDTH;
    localparam int RANDOM_ITEMS = 450;
    localparam int HOLD_CYCLES  = 5000;
    localparam int END_DRAIN    = 1200;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int MAX_REPORTS  = 10;
    localparam string DIGIT_SET = "0123456789abcdefghijklmnopqrstuvwxyz";

    typedef enum int {
        ROW_PREDICTED,
        ROW_TEXT,
        ROW_BAD_BASE
    } row_kind_t;

    typedef struct {
        logic [VALUE_WIDTH-1:0] number;
        logic [RADIX_W-1:0]     radix;
        row_kind_t              kind;
        string                  text;
    } stim_row_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              final_res;
        logic              bad_base;
    } char_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    itoa_in_if #(.VALUE_WIDTH(VALUE_WIDTH)) num_ch ();
    itoa_out_if                             char_ch ();

    int_to_radix_string_top #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .num_ch  (num_ch),
        .char_ch (char_ch)
    );

    // predictor state, mirrors the converter's registers
    logic [VALUE_WIDTH-1:0] div_quotient;
    logic [DIGIT_W-1:0]     digit_buf [MAX_DIGITS];
    int unsigned            n_digits;
    logic                   sign_neg;

    char_beat_t  expected_chars[$];
    stim_row_t   directed_rows[$];
    int unsigned mismatch_count;
    int unsigned beat_count;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    logic        hold_request;
    logic        receiver_hold;

    // clock, period 2
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // text of one conversion, pushed as expected character beats
    task automatic predict_text(input logic [VALUE_WIDTH-1:0] num,
                                input logic [RADIX_W-1:0] rad);
        char_beat_t beat;
        int unsigned pos;
        if (rad < MIN_RADIX || rad > MAX_RADIX)
        begin
            // bad base: one flagged beat, state untouched
            beat = '{NO_CHAR, 1'b1, 1'b1};
            expected_chars.push_back(beat);
            return;
        end
        sign_neg     = num[VALUE_WIDTH-1];
        // unsigned magnitude, so the most negative value needs no special care
        div_quotient = sign_neg ? (~num + 1'b1) : num;
        n_digits     = 0;
        do
        begin
            if (n_digits < MAX_DIGITS)
            begin
                digit_buf[n_digits] = DIGIT_W'(div_quotient % rad);
                n_digits++;
            end
            div_quotient = div_quotient / rad;
        end
        while (div_quotient != 0);
        if (sign_neg)
        begin
            beat = '{MINUS_CODE, 1'b0, 1'b0};
            expected_chars.push_back(beat);
        end
        for (pos = n_digits; pos > 0; pos--)
        begin
            beat.char_code = CHAR_W'(DIGIT_SET[digit_buf[pos-1]]);
            beat.final_res = (pos == 1);
            beat.bad_base  = 1'b0;
            expected_chars.push_back(beat);
        end
    endtask

    // typed-in text for directed rows
    task automatic push_text(input string text);
        char_beat_t beat;
        for (int i = 0; i < text.len(); i++)
        begin
            beat.char_code = CHAR_W'(text[i]);
            beat.final_res = (i == text.len() - 1);
            beat.bad_base  = 1'b0;
            expected_chars.push_back(beat);
        end
    endtask

    // offer one number beat, record the expectation once accepted
    task automatic offer_item(input logic [VALUE_WIDTH-1:0] num,
                              input logic [RADIX_W-1:0] rad,
                              input row_kind_t kind, input string text);
        char_beat_t beat;
        while ($urandom_range(99) < send_idle_pct)
        begin
            num_ch.valid <= 1'b0;
            @(posedge clk);
        end
        num_ch.valid  <= 1'b1;
        num_ch.number <= num;
        num_ch.radix  <= rad;
        @(posedge clk);
        while (!num_ch.ready)
        begin
            @(posedge clk);
        end
        case (kind)
            ROW_TEXT:
            begin
                push_text(text);
            end
            ROW_BAD_BASE:
            begin
                beat = '{NO_CHAR, 1'b1, 1'b1};
                expected_chars.push_back(beat);
            end
            default:
            begin
                predict_text(num, rad);
            end
        endcase
    endtask

    // random item: mostly valid bases, values spread over extremes, small
    // values, full-range values and values around powers of the base
    task automatic pick_random_item(output logic [VALUE_WIDTH-1:0] num,
                                    output logic [RADIX_W-1:0] rad);
        int unsigned sel;
        int unsigned pick;
        int unsigned k;
        longint unsigned power;
        if ($urandom_range(99) < 8)
        begin
            pick = $urandom_range(29);
            rad  = (pick < 2) ? RADIX_W'(pick) : RADIX_W'(pick + 34);
        end
        else
        begin
            rad = RADIX_W'($urandom_range(MAX_RADIX, MIN_RADIX));
        end
        sel = $urandom_range(9);
        if (sel <= 3 || sel >= 8)
        begin
            num = $urandom;
        end
        else if (sel <= 5)
        begin
            num = $urandom_range(2000);
            if ($urandom_range(1))
            begin
                num = -num;
            end
        end
        else if (sel == 6)
        begin
            // one below, at or above a power of the base
            k     = $urandom_range(31, 1);
            power = 1;
            for (int i = 0; i < k; i++)
            begin
                if (power * rad <= 64'h7FFF_FFFF && rad >= MIN_RADIX)
                begin
                    power = power * rad;
                end
            end
            num = VALUE_WIDTH'(power + $urandom_range(2) - 1);
            if ($urandom_range(1))
            begin
                num = -num;
            end
        end
        else
        begin
            case ($urandom_range(4))
                0:       num = 32'h8000_0000;
                1:       num = 32'h7FFF_FFFF;
                2:       num = 32'hFFFF_FFFF;
                3:       num = 32'h0000_0001;
                default: num = '0;
            endcase
        end
    endtask

    // compare one character beat with the oldest expectation
    task automatic check_char_beat();
        char_beat_t got;
        char_beat_t want;
        got = '{char_ch.char_code, char_ch.final_res, char_ch.bad_base};
        beat_count++;
        if (expected_chars.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
            begin
                $display("char beat %0d: nothing expected, got char %0d final %0b bad %0b",
                         beat_count, got.char_code, got.final_res, got.bad_base);
            end
            return;
        end
        want = expected_chars.pop_front();
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
            begin
                $display("char beat %0d: exp char %0d final %0b bad %0b, got char %0d final %0b bad %0b",
                         beat_count, want.char_code, want.final_res, want.bad_base,
                         got.char_code, got.final_res, got.bad_base);
            end
        end
    endtask

    // receive side: check, then choose ready for the next edge
    always @(posedge clk)
    begin
        if (char_ch.valid && char_ch.ready)
        begin
            check_char_beat();
        end
        if (receiver_hold)
        begin
            char_ch.ready <= 1'b0;
        end
        else
        begin
            char_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off, counted here so the block backs up
    initial
    begin
        receiver_hold = 1'b0;
        wait (hold_request);
        receiver_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        receiver_hold <= 1'b0;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_int_to_radix_string_top: FAIL");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        logic [VALUE_WIDTH-1:0] num;
        logic [RADIX_W-1:0]     rad;
        int unsigned            phase_items [4];
        int unsigned            phase_idle [4];
        int unsigned            phase_stall [4];

        rst_n          = 1'b0;
        num_ch.valid   = 1'b0;
        num_ch.number  = '0;
        num_ch.radix   = '0;
        mismatch_count = 0;
        beat_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        sign_neg       = 1'b0;
        n_digits       = 0;
        div_quotient   = '0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            digit_buf[i] = '0;
        end

        // directed rows: extremes, bad bases, every digit range
        directed_rows.push_back('{32'd0,           6'd10, ROW_TEXT,      "0"});
        directed_rows.push_back('{32'd0,           6'd2,  ROW_TEXT,      "0"});
        directed_rows.push_back('{32'd0,           6'd35, ROW_TEXT,      "0"});
        directed_rows.push_back('{32'd1,           6'd35, ROW_TEXT,      "1"});
        directed_rows.push_back('{-32'sd1,         6'd10, ROW_TEXT,      "-1"});
        directed_rows.push_back('{-32'sd1,         6'd2,  ROW_TEXT,      "-1"});
        directed_rows.push_back('{32'h7FFF_FFFF,   6'd10, ROW_TEXT,      "2147483647"});
        directed_rows.push_back('{32'h8000_0000,   6'd10, ROW_TEXT,      "-2147483648"});
        directed_rows.push_back('{32'h7FFF_FFFF,   6'd16, ROW_TEXT,      "7fffffff"});
        directed_rows.push_back('{32'h8000_0000,   6'd16, ROW_TEXT,      "-80000000"});
        directed_rows.push_back('{32'd255,         6'd16, ROW_TEXT,      "ff"});
        directed_rows.push_back('{32'd9,           6'd10, ROW_TEXT,      "9"});
        directed_rows.push_back('{32'd10,          6'd11, ROW_TEXT,      "a"});
        directed_rows.push_back('{32'd34,          6'd35, ROW_TEXT,      "y"});
        directed_rows.push_back('{32'd35,          6'd35, ROW_TEXT,      "10"});
        directed_rows.push_back('{-32'sd35,        6'd35, ROW_TEXT,      "-10"});
        directed_rows.push_back('{32'd12345,       6'd0,  ROW_BAD_BASE,  ""});
        directed_rows.push_back('{32'd12345,       6'd1,  ROW_BAD_BASE,  ""});
        directed_rows.push_back('{32'd5,           6'd36, ROW_BAD_BASE,  ""});
        directed_rows.push_back('{-32'sd7,         6'd63, ROW_BAD_BASE,  ""});
        directed_rows.push_back('{32'h8000_0000,   6'd2,  ROW_PREDICTED, ""});
        directed_rows.push_back('{32'h7FFF_FFFF,   6'd2,  ROW_PREDICTED, ""});
        directed_rows.push_back('{32'h8000_0000,   6'd35, ROW_PREDICTED, ""});
        directed_rows.push_back('{32'h7FFF_FFFF,   6'd35, ROW_PREDICTED, ""});
        directed_rows.push_back('{32'hA5C3_0F96,   6'd7,  ROW_PREDICTED, ""});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            offer_item(directed_rows[i].number, directed_rows[i].radix,
                       directed_rows[i].kind, directed_rows[i].text);
        end

        // back-pressure: receiver held off while the sender keeps offering
        hold_request = 1'b1;
        for (int i = 0; i < 30; i++)
        begin
            pick_random_item(num, rad);
            offer_item(num, rad, ROW_PREDICTED, "");
        end

        // idle phases: none, sender gaps, receiver stalls, both
        phase_items = '{120, 100, 100, 100};
        phase_idle  = '{0, 84, 0, 31};
        phase_stall = '{0, 0, 84, 31};
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            for (int i = 0; i < phase_items[p]; i++)
            begin
                pick_random_item(num, rad);
                offer_item(num, rad, ROW_PREDICTED, "");
            end
        end
        num_ch.valid <= 1'b0;

        // drain, then watch for stray beats
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (END_DRAIN) @(posedge clk);

        if (mismatch_count == 0 && expected_chars.size() == 0)
        begin
            $display("tb_int_to_radix_string_top: PASS");
        end
        else
        begin
            $display("tb_int_to_radix_string_top: FAIL");
        end
        $finish;
    end

endmodule
